>>> rtl/cfs_pkg.sv
`default_nettype none

package cfs_pkg;

	localparam int CMD_W    = 2;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 5;
	localparam int LEN_W    = 5;

	localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MATCH      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOMATCH    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ELEM       = 3'd5;
	localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 3'd6;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/cfs_ifs.sv
`default_nettype none

interface cfs_req_if;
	logic                              valid;
	logic                              ready;
	logic [cfs_pkg::CMD_W-1:0]         cmd;
	logic signed [cfs_pkg::DATA_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

interface cfs_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [cfs_pkg::STATUS_W-1:0]      status;
	logic [cfs_pkg::POS_W-1:0]         position;
	logic signed [cfs_pkg::DATA_W-1:0] data;
	logic                              last;

	modport source (output valid, output status, output position, output data, output last,
		input ready);
	modport sink (input valid, input status, input position, input data, input last,
		output ready);
endinterface

`default_nettype wire

>>> rtl/cfs_ram.sv
`default_nettype none

module cfs_ram #(
	parameter int DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(DEPTH)-1:0]      waddr,
	input  wire logic [cfs_pkg::DATA_W-1:0]    wdata,
	input  wire logic                          re,
	input  wire logic [$clog2(DEPTH)-1:0]      raddr,
	output      logic [cfs_pkg::DATA_W-1:0]    rdata
);

	logic [cfs_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/circular_fifo_with_search_top.sv
`default_nettype none

// Ring-buffer queue of signed 32-bit words held in one synchronous memory of DEPTH entries,
// of which the first queue_length (clamped to 1..DEPTH) are in use; writing queue_length
// empties the queue. Every request yields one or more results on rsp, the final one marked
// by last. Enqueue and dequeue can run back to back while results are taken. Search and
// dump walk the occupied entries through the single memory read port, one entry per cycle
// while rsp is not stalled; a stalled rsp channel holds the walk, and no new request is
// taken until the final result is loaded. Either on an empty queue gives a single result.
// No clearing pass is needed after reset.
module circular_fifo_with_search_top #(
	parameter int DEPTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cfs_pkg::LEN_W-1:0]   cfg_wdata,
	cfs_req_if.sink                          req,
	cfs_rsp_if.source                        rsp
);

	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int RST_N = (16 > DEPTH) ? DEPTH : 16;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q;

	logic [PW-1:0] head_q, tail_q, rd_ptr_q;
	logic          full_q;
	logic [NW-1:0] n_q, remain_q, pos_q;
	logic [NW-1:0] occ, cfg_n;
	logic          dump_q;
	logic [cfs_pkg::DATA_W-1:0] val_q;

	logic          valid_s1, last_s1;
	logic [NW-1:0] pos_s1;
	logic          pend_valid_q;
	logic [NW-1:0] pend_pos_q;

	logic          out_valid_q;
	cfs_pkg::rsp_t out_q, out_next;
	logic          out_load, out_free;

	logic          req_fire, is_full, ring_empty, hit_s1, s1_take, issue, ram_we;
	logic [PW-1:0] tail_adv, head_adv, rd_adv;
	logic [cfs_pkg::DATA_W-1:0] rdata;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] i, input logic [NW-1:0] n);
		logic [NW-1:0] nx;
		nx = NW'(i) + NW'(1);
		return (nx == n) ? '0 : PW'(nx);
	endfunction

	cfs_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (req.value),
		.re    (issue),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_n = NW'(1);
		end else if (int'(cfg_wdata) > DEPTH) begin
			cfg_n = NW'(DEPTH);
		end else begin
			cfg_n = NW'(cfg_wdata);
		end
	end

	assign is_full    = (head_q == tail_q) && full_q;
	assign ring_empty = (head_q == tail_q) && !full_q;
	// modular difference stays below n unless full
	assign occ = is_full ? n_q
		: NW'(NW'(tail_q) - NW'(head_q) + ((tail_q < head_q) ? n_q : NW'(0)));

	assign tail_adv = adv(tail_q, n_q);
	assign head_adv = adv(head_q, n_q);
	assign rd_adv   = adv(rd_ptr_q, n_q);

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign ram_we    = req_fire && (req.cmd == cfs_pkg::CMD_ENQ) && !is_full;

	assign hit_s1 = (rdata == val_q);
	// a new match only needs the output when an older match is waiting to go out
	assign s1_take = valid_s1 && (dump_q ? out_free : (!(hit_s1 && pend_valid_q) || out_free));
	assign issue   = (state_q == S_WALK) && (remain_q != '0) && (!valid_s1 || s1_take);

	always_comb begin
		out_load = 1'b0;
		out_next = '{status: cfs_pkg::ST_DONE, position: '0, data: '0, last: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (req.cmd)
						cfs_pkg::CMD_ENQ: begin
							out_load = 1'b1;
							out_next.status = is_full ? cfs_pkg::ST_FULL : cfs_pkg::ST_DONE;
						end
						cfs_pkg::CMD_DEQ: begin
							out_load = 1'b1;
							out_next.status = ring_empty ? cfs_pkg::ST_EMPTY : cfs_pkg::ST_DONE;
						end
						cfs_pkg::CMD_SEARCH: begin
							out_load = (occ == '0);
							out_next.status = cfs_pkg::ST_NOMATCH;
						end
						cfs_pkg::CMD_DUMP: begin
							out_load = (occ == '0);
							out_next.status = cfs_pkg::ST_DUMP_EMPTY;
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			S_WALK: begin
				if (s1_take) begin
					if (dump_q) begin
						out_load = 1'b1;
						out_next = '{status: cfs_pkg::ST_ELEM, position: cfs_pkg::POS_W'(pos_s1),
							data: $signed(rdata), last: last_s1};
					end else if (hit_s1 && pend_valid_q) begin
						out_load = 1'b1;
						out_next = '{status: cfs_pkg::ST_MATCH,
							position: cfs_pkg::POS_W'(pend_pos_q), data: '0, last: 1'b0};
					end
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					if (pend_valid_q) begin
						out_next.status   = cfs_pkg::ST_MATCH;
						out_next.position = cfs_pkg::POS_W'(pend_pos_q);
					end else begin
						out_next.status = cfs_pkg::ST_NOMATCH;
					end
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			full_q       <= 1'b0;
			n_q          <= NW'(RST_N);
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			remain_q     <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						case (req.cmd)
							cfs_pkg::CMD_ENQ: begin
								if (!is_full) begin
									tail_q <= tail_adv;
									full_q <= (tail_adv == head_q);
								end
							end
							cfs_pkg::CMD_DEQ: begin
								if (!ring_empty) begin
									head_q <= head_adv;
									full_q <= 1'b0;
								end
							end
							cfs_pkg::CMD_SEARCH, cfs_pkg::CMD_DUMP: begin
								if (occ != '0) begin
									state_q      <= S_WALK;
									remain_q     <= occ;
									pend_valid_q <= 1'b0;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (issue) begin
						remain_q <= remain_q - NW'(1);
						valid_s1 <= 1'b1;
					end else if (s1_take) begin
						valid_s1 <= 1'b0;
					end
					if (s1_take && !dump_q && hit_s1) begin
						pend_valid_q <= 1'b1;
					end
					if (s1_take && last_s1) begin
						state_q <= dump_q ? S_IDLE : S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// a length write empties the queue
			if (cfg_we) begin
				head_q <= '0;
				tail_q <= '0;
				full_q <= 1'b0;
				n_q    <= cfg_n;
			end
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rd_ptr_q <= head_q;
			pos_q    <= NW'(1);
			val_q    <= req.value;
			dump_q   <= (req.cmd == cfs_pkg::CMD_DUMP);
		end
		if (issue) begin
			rd_ptr_q <= rd_adv;
			pos_q    <= pos_q + NW'(1);
			pos_s1   <= pos_q;
			last_s1  <= (remain_q == NW'(1));
		end
		if (s1_take && !dump_q && hit_s1) begin
			pend_pos_q <= pos_s1;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_q.status;
	assign rsp.position = out_q.position;
	assign rsp.data     = out_q.data;
	assign rsp.last     = out_q.last;

endmodule

`default_nettype wire
